// ===== sv/spectrum_bar_peak_meter_render_defines.svh =====
// ----------------------------------------------------------------------------
// Spectrum bar peak meter - assertion macros
// Shared concurrent assertion macros, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAR_PEAK_METER_RENDER_DEFINES_SVH
`define SPECTRUM_BAR_PEAK_METER_RENDER_DEFINES_SVH

`ifndef SYNTHESIS
// Assert a property on every rising clock edge outside reset
`define SBPM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sbpm assertion failed");
// Assert that a condition never holds outside reset
`define SBPM_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("sbpm forbidden condition");
`else
`define SBPM_ASSERT(lbl, clk, rst, prop)
`define SBPM_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== sv/sbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Spectrum bar peak meter - package
// Shared types, register codes and per-column arithmetic helpers.
// ----------------------------------------------------------------------------
package sbpm_pkg;

   // Register indexes of the csr port
   typedef enum logic [2:0] {
      CSR_BODY_GRAY       = 3'd0,
      CSR_PEAK_GRAY       = 3'd1,
      CSR_FADE_ROWS       = 3'd2,
      CSR_DOT_HOLD_FRAMES = 3'd3,
      CSR_DOT_FALL_STEP   = 3'd4,
      CSR_DOT_FLOOR_LEVEL = 3'd5,
      CSR_BAR_FALL_GAIN   = 3'd6
   } sbpm_csr_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [3:0]         body_gray;
      logic [3:0]         peak_gray;
      logic [3:0]         fade_rows;
      logic [7:0]         dot_hold_frames;
      logic [14:0]        dot_fall_step;
      logic signed [15:0] dot_floor_level;
      logic [7:0]         bar_fall_gain;
   } sbpm_cfg_type;

   localparam sbpm_cfg_type CFG_RESET = '{
      body_gray:       4'd15,
      peak_gray:       4'd15,
      fade_rows:       4'd4,
      dot_hold_frames: 8'd30,
      dot_fall_step:   15'd256,
      dot_floor_level: 16'sd0,
      bar_fall_gain:   8'd1
   };

   // Item handed from the front to the back (pair already wrapped)
   typedef struct packed {
      logic [6:0]  pair;
      logic [14:0] height_even;
      logic [14:0] height_odd;
   } sbpm_item_type;

   // Stored state of one column
   typedef struct packed {
      logic [14:0]        bar;
      logic signed [15:0] dot;
      logic [7:0]         hold;
   } sbpm_col_type;

   typedef struct packed {
      sbpm_col_type even;
      sbpm_col_type odd;
   } sbpm_pair_type;

   // Display levels of one pair, handed to the row renderer
   typedef struct packed {
      logic [5:0]        bar_even;
      logic [5:0]        bar_odd;
      logic signed [6:0] dot_even;
      logic signed [6:0] dot_odd;
   } sbpm_job_type;

   // Piecewise-linear exponential fall step: ((8 + lvl[2:0]) << lvl[5:3]) - 8
   function automatic logic [10:0] fall_step_of(logic [5:0] lvl);
      logic [10:0] base;
      base = {7'd0, 1'b1, lvl[2:0]};
      return (base << lvl[5:3]) - 11'd8;
   endfunction

   // Raise bar to a higher new height; a lower dot follows and reloads its hold
   function automatic sbpm_col_type rise_col(sbpm_col_type s, logic [14:0] h,
                                             logic [7:0] frames);
      sbpm_col_type n;
      n = s;
      if (h > s.bar) n.bar = h;
      if ($signed(s.dot) < $signed({1'b0, n.bar})) begin
         n.dot  = {1'b0, n.bar};
         n.hold = frames;
      end
      return n;
   endfunction

   // Drop bar by the scaled step (floor 0); drop dot after its hold expires
   function automatic sbpm_col_type fall_col(sbpm_col_type s, logic [18:0] step,
                                             logic [14:0] dot_step,
                                             logic signed [15:0] floor_lvl);
      sbpm_col_type     n;
      logic signed [16:0] d;
      n = s;
      n.bar = ({4'd0, s.bar} < step) ? 15'd0 : s.bar - step[14:0];
      d = $signed({s.dot[15], s.dot}) - $signed({2'b00, dot_step});
      if (s.hold == 8'd0) begin
         n.dot = (d < $signed({floor_lvl[15], floor_lvl})) ? floor_lvl : d[15:0];
      end else begin
         n.hold = s.hold - 8'd1;
      end
      return n;
   endfunction

   // Gray level of one pixel: bar body, fade band at the top, dot ORed in
   function automatic logic [3:0] pixel_of(logic [5:0] bar_lvl,
                                           logic signed [6:0] dot_lvl,
                                           logic [5:0] row, sbpm_cfg_type cfg);
      logic signed [7:0] h;
      logic signed [7:0] f;
      logic signed [7:0] v;
      logic [3:0]        pix;
      h = $signed({2'b00, bar_lvl}) - $signed({2'b00, row});
      f = $signed({4'd0, cfg.fade_rows});
      if (h > f) begin
         v = $signed({4'd0, cfg.body_gray});
      end else if (h >= 8'sd0) begin
         v = $signed({4'd0, cfg.body_gray}) - (f - h) - 8'sd1;
      end else begin
         v = 8'sd0;
      end
      pix = (v < 8'sd0) ? 4'd0 : v[3:0];
      if (dot_lvl == $signed({1'b0, row})) pix = pix | cfg.peak_gray;
      return pix;
   endfunction

endpackage

// ===== sv/sbpm_front.sv =====
// ----------------------------------------------------------------------------
// Spectrum bar peak meter - front end
// Accepts request words, wraps the pair index and queues up to two items.
// ----------------------------------------------------------------------------
module sbpm_front
   import sbpm_pkg::*;
#(
   parameter int COLUMNS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  clr_busy,
   output logic                  item_vld,
   output sbpm_item_type         item,
   input  logic                  item_pop
);

   localparam int PAIRS = COLUMNS / 2;

   typedef logic [6:0] pair_map_type [128];

   // Wrap table: index modulo the number of pairs
   function automatic pair_map_type build_pair_map();
      pair_map_type m;
      int           k;
      k = 0;
      for (int i = 0; i < 128; i++) begin
         m[i] = 7'(k);
         k    = (k + 1 == PAIRS) ? 0 : k + 1;
      end
      return m;
   endfunction

   localparam pair_map_type PAIR_MAP = build_pair_map();

   sbpm_item_type q_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          push;
   sbpm_item_type new_item;

   // Take a word while there is room and the state memory is ready
   assign req_tready = (cnt_ff != 2'd2) && !clr_busy;
   assign push       = req_tvalid && req_tready;

   // Classify: wrap the pair and split the fields
   always_comb begin
      new_item.pair        = PAIR_MAP[req_tdata[6:0]];
      new_item.height_even = req_tdata[21:7];
      new_item.height_odd  = req_tdata[36:22];
   end

   assign item_vld = (cnt_ff != 2'd0);
   assign item     = q_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !item_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && item_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== sv/sbpm_back.sv =====
// ----------------------------------------------------------------------------
// Spectrum bar peak meter - state update
// Reads pair state, applies rise, hands levels to the renderer, applies
// fall and writes the state back. Clears the state memory after reset.
// ----------------------------------------------------------------------------
`include "spectrum_bar_peak_meter_render_defines.svh"

module sbpm_back
   import sbpm_pkg::*;
#(
   parameter int COLUMNS = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  sbpm_cfg_type  cfg,
   input  logic          item_vld,
   input  sbpm_item_type item,
   output logic          item_pop,
   output logic          clr_busy,
   output logic          job_vld,
   output sbpm_job_type  job,
   input  logic          job_take
);

   localparam int PAIRS = COLUMNS / 2;
   localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

   sbpm_pair_type mem_ff [PAIRS];

   logic          clr_ff, clr_in;
   logic [PW-1:0] clr_addr_ff, clr_addr_in;

   logic          rd_vld_ff;
   logic [PW-1:0] rd_addr_ff;
   logic [14:0]   rd_he_ff, rd_ho_ff;
   sbpm_pair_type rd_data_ff;

   logic          rs_vld_ff;
   logic [PW-1:0] rs_addr_ff;
   sbpm_pair_type rs_state_ff, rs_state_in;

   logic          ml_vld_ff;
   logic [PW-1:0] ml_addr_ff;
   sbpm_pair_type ml_state_ff;
   logic [18:0]   ml_prod_e_ff, ml_prod_e_in;
   logic [18:0]   ml_prod_o_ff, ml_prod_o_in;

   logic          job_vld_ff, job_vld_in;
   sbpm_job_type  job_ff, job_in;

   logic [PW-1:0] pop_addr;
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   sbpm_pair_type wr_data;

   assign clr_busy = clr_ff;
   assign job_vld  = job_vld_ff;
   assign job      = job_ff;
   assign pop_addr = PW'(item.pair);

   // Pop only when the previous write-back is done and the job slot is free
   assign item_pop = item_vld && !clr_ff && !rd_vld_ff && !rs_vld_ff && !ml_vld_ff
                     && !job_vld_ff;

   // Clearing pass over all pairs after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + PW'(1);
         if (clr_addr_ff == PW'(PAIRS - 1)) clr_in = 1'b0;
      end
   end

   // Rise on the fresh read; derive display levels for the renderer
   always_comb begin
      rs_state_in.even = rise_col(rd_data_ff.even, rd_he_ff, cfg.dot_hold_frames);
      rs_state_in.odd  = rise_col(rd_data_ff.odd, rd_ho_ff, cfg.dot_hold_frames);
      job_in.bar_even  = rs_state_in.even.bar[14:9];
      job_in.bar_odd   = rs_state_in.odd.bar[14:9];
      job_in.dot_even  = rs_state_in.even.dot[15:9];
      job_in.dot_odd   = rs_state_in.odd.dot[15:9];
      job_vld_in       = job_vld_ff;
      if (rd_vld_ff) begin
         job_vld_in = 1'b1;
      end else if (job_take) begin
         job_vld_in = 1'b0;
      end
   end

   // Scale the fall step of the bar level by the gain
   always_comb begin
      ml_prod_e_in = 19'(cfg.bar_fall_gain) * 19'(fall_step_of(rs_state_ff.even.bar[14:9]));
      ml_prod_o_in = 19'(cfg.bar_fall_gain) * 19'(fall_step_of(rs_state_ff.odd.bar[14:9]));
   end

   // Write port: clearing pass or fall write-back
   always_comb begin
      wr_en        = clr_ff || ml_vld_ff;
      wr_addr      = clr_ff ? clr_addr_ff : ml_addr_ff;
      wr_data.even = fall_col(ml_state_ff.even, ml_prod_e_ff, cfg.dot_fall_step,
                              cfg.dot_floor_level);
      wr_data.odd  = fall_col(ml_state_ff.odd, ml_prod_o_ff, cfg.dot_fall_step,
                              cfg.dot_floor_level);
      if (clr_ff) wr_data = '0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         rd_vld_ff   <= 1'b0;
         rs_vld_ff   <= 1'b0;
         ml_vld_ff   <= 1'b0;
         job_vld_ff  <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         rd_vld_ff   <= item_pop;
         rs_vld_ff   <= rd_vld_ff;
         ml_vld_ff   <= rs_vld_ff;
         job_vld_ff  <= job_vld_in;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (item_pop) begin
         rd_addr_ff <= pop_addr;
         rd_he_ff   <= item.height_even;
         rd_ho_ff   <= item.height_odd;
      end
      if (rd_vld_ff) begin
         rs_addr_ff  <= rd_addr_ff;
         rs_state_ff <= rs_state_in;
         job_ff      <= job_in;
      end
      if (rs_vld_ff) begin
         ml_addr_ff   <= rs_addr_ff;
         ml_state_ff  <= rs_state_ff;
         ml_prod_e_ff <= ml_prod_e_in;
         ml_prod_o_ff <= ml_prod_o_in;
      end
   end

   // State memory: registered read, single write
   always_ff @(posedge clock) begin
      if (item_pop) begin
         rd_data_ff <= mem_ff[pop_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   `SBPM_ASSERT_NEVER(a_pop_in_clear, clock, reset, item_pop && clr_ff)
   `SBPM_ASSERT(a_one_in_flight, clock, reset, $onehot0({rd_vld_ff, rs_vld_ff, ml_vld_ff}))
   `SBPM_ASSERT(a_job_slot_free, clock, reset, rd_vld_ff |-> !job_vld_ff)

endmodule

// ===== sv/sbpm_render.sv =====
// ----------------------------------------------------------------------------
// Spectrum bar peak meter - row renderer
// Emits one row byte per cycle for the current pair, while rsp_tready allows, into an output register.
// ----------------------------------------------------------------------------
`include "spectrum_bar_peak_meter_render_defines.svh"

module sbpm_render
   import sbpm_pkg::*;
#(
   parameter int ROWS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sbpm_cfg_type          cfg,
   input  logic                  job_vld,
   input  sbpm_job_type          job,
   output logic                  job_take,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam logic [5:0] LAST_ROW = 6'(ROWS - 1);

   logic         ren_vld_ff, ren_vld_in;
   logic [5:0]   row_ff, row_in;
   sbpm_job_type cur_ff;
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [5:0]   out_row_ff;
   logic [7:0]   out_pix_ff;
   logic         out_last_ff;
   logic         out_free, gen, last_gen;
   logic [7:0]   pix;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign gen      = ren_vld_ff && out_free;
   assign last_gen = gen && (row_ff == LAST_ROW);
   assign job_take = job_vld && (!ren_vld_ff || last_gen);

   assign pix = {pixel_of(cur_ff.bar_even, cur_ff.dot_even, row_ff, cfg),
                 pixel_of(cur_ff.bar_odd, cur_ff.dot_odd, row_ff, cfg)};

   // Advance the row counter; load the next pair after the last row
   always_comb begin
      ren_vld_in = ren_vld_ff;
      row_in     = row_ff;
      if (job_take) begin
         ren_vld_in = 1'b1;
         row_in     = 6'd0;
      end else if (last_gen) begin
         ren_vld_in = 1'b0;
      end else if (gen) begin
         row_in = row_ff + 6'd1;
      end
      rsp_tvalid_in = gen ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ren_vld_ff    <= 1'b0;
         row_ff        <= 6'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         ren_vld_ff    <= ren_vld_in;
         row_ff        <= row_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Output register and current pair levels
   always_ff @(posedge clock) begin
      if (job_take) begin
         cur_ff <= job;
      end
      if (gen) begin
         out_row_ff  <= row_ff;
         out_pix_ff  <= pix;
         out_last_ff <= (row_ff == LAST_ROW);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, out_pix_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;

   `SBPM_ASSERT(a_row_range, clock, reset, ren_vld_ff |-> (row_ff <= LAST_ROW))
   `SBPM_ASSERT(a_last_row, clock, reset, (rsp_tvalid_ff && out_last_ff) |-> (out_row_ff == LAST_ROW))
   `SBPM_ASSERT(a_idle_after_last, clock, reset, (last_gen && !job_vld) |=> !ren_vld_ff)

endmodule

// ===== sv/spectrum_bar_peak_meter_render.sv =====
// ----------------------------------------------------------------------------
// Spectrum bar peak meter render - top level
// Peak-hold bar graph: per column pair, rise, render ROWS gray row bytes,
// then fall of bar and peak dot.
// ----------------------------------------------------------------------------
//  Channel | Direction | Word
//  req     | in        | one column pair with two new heights
//  rsp     | out       | one row byte; tlast on the top row of the pair
//  csr     | in        | register write, no read-back
//
//  The renderer emits one row byte a cycle while rsp_tready is high. The state
//  read, rise, fall and write-back of the next pair run while the previous
//  pair renders. After reset a clearing pass zeroes the state of every pair;
//  req_tready is low meanwhile. rsp_tready low holds the renderer; a two-word
//  queue buffers req words until it is full.
// ----------------------------------------------------------------------------
module spectrum_bar_peak_meter_render
   import sbpm_pkg::*;
#(
   parameter int COLUMNS = 256,
   parameter int ROWS    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: pair_index[6:0], height_even[21:7], height_odd[36:22], zero[39:37]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: row_index[5:0], pixel_byte[13:6], zero[15:14]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   sbpm_cfg_type  cfg_ff, cfg_in;
   logic          item_vld, item_pop, clr_busy;
   sbpm_item_type item;
   logic          job_vld, job_take;
   sbpm_job_type  job;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_BODY_GRAY:       cfg_in.body_gray       = csr_wdata[3:0];
            CSR_PEAK_GRAY:       cfg_in.peak_gray       = csr_wdata[3:0];
            CSR_FADE_ROWS:       cfg_in.fade_rows       = csr_wdata[3:0];
            CSR_DOT_HOLD_FRAMES: cfg_in.dot_hold_frames = csr_wdata[7:0];
            CSR_DOT_FALL_STEP:   cfg_in.dot_fall_step   = csr_wdata[14:0];
            CSR_DOT_FLOOR_LEVEL: cfg_in.dot_floor_level = csr_wdata[15:0];
            CSR_BAR_FALL_GAIN:   cfg_in.bar_fall_gain   = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbpm_front #(
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .clr_busy   (clr_busy),
      .item_vld   (item_vld),
      .item       (item),
      .item_pop   (item_pop)
   );

   sbpm_back #(
      .COLUMNS (COLUMNS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .item_vld (item_vld),
      .item     (item),
      .item_pop (item_pop),
      .clr_busy (clr_busy),
      .job_vld  (job_vld),
      .job      (job),
      .job_take (job_take)
   );

   sbpm_render #(
      .ROWS (ROWS)
   ) u_render (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_vld    (job_vld),
      .job        (job),
      .job_take   (job_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== sim/meter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peak meter checker
// Watches the pair, row and register channels of the bar graph renderer.
// Keeps its own copy of the per-column bar, dot and hold state and predicts
// the row words of every accepted pair, then compares each returned row word
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module meter_checker
   import sbpm_pkg::*;
#(
   parameter int COLUMNS = 256,
   parameter int ROWS    = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // pair_index[6:0], height_even[21:7], height_odd[36:22], zero[39:37]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // row_index[5:0], pixel_byte[13:6], zero[15:14]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    rows_open,
   output int                    error_count,
   output int                    pairs_seen,
   output int                    rows_checked
);

   localparam int LEVEL_SHIFT = 9;
   localparam int STEP_DEPTH  = 64;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [6:0] pair;
      logic [5:0] row;
      logic [7:0] pixels;
      logic       last;
   } row_word_type;

   sbpm_cfg_type       regs;
   logic [14:0]        bar_h     [COLUMNS];
   logic signed [15:0] dot_h     [COLUMNS];
   logic [7:0]         hold_left [COLUMNS];
   logic [10:0]        fall_rom  [STEP_DEPTH];
   row_word_type       rows_due  [$];

   // Piecewise-linear exponential bar fall steps, indexed by display level
   initial begin
      for (int i = 0; i < STEP_DEPTH; i++)
         fall_rom[i] = 11'(((1 << (i >> 3)) * (8 + (i & 7))) - 8);
   end

   // Display level: floor division by 512
   function automatic int level_of(int h);
      return h >>> LEVEL_SHIFT;
   endfunction

   // Gray level of one pixel: bar body, fade band below its top, dot on top
   function automatic logic [3:0] gray_of(int bar_lvl, int dot_lvl, int row);
      int         h;
      int         v;
      logic [3:0] g;
      h = bar_lvl - row;
      if (h > int'(regs.fade_rows))
         v = int'(regs.body_gray);
      else if (h >= 0)
         v = int'(regs.body_gray) - (int'(regs.fade_rows) - h) - 1;
      else
         v = 0;
      if (v < 0) v = 0;
      g = v[3:0];
      if (dot_lvl == row) g = g | regs.peak_gray;
      return g;
   endfunction

   // Lift bar to a higher height; a lower dot follows and reloads its hold
   function automatic void raise_column(int c, logic [14:0] h);
      int bar;
      int dot;
      if (h > bar_h[c]) bar_h[c] = h;
      bar = int'(bar_h[c]);
      dot = $signed(dot_h[c]);
      if (dot < bar) begin
         dot_h[c]     = 16'(bar);
         hold_left[c] = regs.dot_hold_frames;
      end
   endfunction

   // Drop bar by the scaled step; drop dot once its hold has run out
   function automatic void lower_column(int c);
      int lvl;
      int step;
      int b;
      int d;
      int flr;
      lvl  = level_of(int'(bar_h[c]));
      step = int'(regs.bar_fall_gain) *
             int'(fall_rom[(lvl < 0) ? 0 : (lvl & (STEP_DEPTH - 1))]);
      b = int'(bar_h[c]) - step;
      bar_h[c] = (b < 0) ? 15'd0 : b[14:0];
      if (hold_left[c] == 8'd0) begin
         d   = $signed(dot_h[c]);
         d   = d - int'(regs.dot_fall_step);
         flr = $signed(regs.dot_floor_level);
         if (d < flr) d = flr;
         dot_h[c] = d[15:0];
      end else begin
         hold_left[c] = hold_left[c] - 8'd1;
      end
   endfunction

   // Update one pair and queue all of its row words, bottom row first
   function automatic void render_pair(logic [6:0] pair_field, logic [14:0] h_even,
                                       logic [14:0] h_odd);
      int           p;
      int           ce;
      int           co;
      row_word_type w;
      p  = int'(pair_field) % (COLUMNS / 2);
      ce = 2 * p;
      co = ce + 1;
      raise_column(ce, h_even);
      raise_column(co, h_odd);
      for (int j = 0; j < ROWS; j++) begin
         w.pair   = pair_field;
         w.row    = j[5:0];
         w.pixels = {gray_of(level_of(int'(bar_h[ce])), level_of($signed(dot_h[ce])), j),
                     gray_of(level_of(int'(bar_h[co])), level_of($signed(dot_h[co])), j)};
         w.last   = (j == ROWS - 1);
         rows_due.push_back(w);
      end
      lower_column(ce);
      lower_column(co);
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, msg);
      error_count = error_count + 1;
   endtask

   always @(posedge clock) begin
      row_word_type got;
      row_word_type want;
      if (reset) begin
         regs = CFG_RESET;
         foreach (bar_h[i]) begin
            bar_h[i]     = '0;
            dot_h[i]     = '0;
            hold_left[i] = '0;
         end
         rows_due.delete();
         error_count  = 0;
         pairs_seen   = 0;
         rows_checked = 0;
      end else begin
         // Compare one returned row word with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.row    = rsp_tdata[5:0];
            got.pixels = rsp_tdata[13:6];
            got.last   = rsp_tlast;
            if (rows_due.size() == 0) begin
               report_mismatch($sformatf("row word for row %0d with no pair pending",
                                         got.row));
            end else begin
               want = rows_due.pop_front();
               rows_checked = rows_checked + 1;
               if (got.row !== want.row)
                  report_mismatch($sformatf("pair %0d row_index got %0d expected %0d",
                                            want.pair, got.row, want.row));
               if (got.pixels !== want.pixels)
                  report_mismatch($sformatf("pair %0d row %0d pixel_byte got %h expected %h",
                                            want.pair, want.row, got.pixels, want.pixels));
               if (got.last !== want.last)
                  report_mismatch($sformatf("pair %0d row %0d last_row got %0b expected %0b",
                                            want.pair, want.row, got.last, want.last));
            end
         end
         // Track register writes; unused indexes are ignored
         if (csr_we) begin
            case (csr_addr)
               CSR_BODY_GRAY:       regs.body_gray       = csr_wdata[3:0];
               CSR_PEAK_GRAY:       regs.peak_gray       = csr_wdata[3:0];
               CSR_FADE_ROWS:       regs.fade_rows       = csr_wdata[3:0];
               CSR_DOT_HOLD_FRAMES: regs.dot_hold_frames = csr_wdata[7:0];
               CSR_DOT_FALL_STEP:   regs.dot_fall_step   = csr_wdata[14:0];
               CSR_DOT_FLOOR_LEVEL: regs.dot_floor_level = csr_wdata;
               CSR_BAR_FALL_GAIN:   regs.bar_fall_gain   = csr_wdata[7:0];
               default: ;
            endcase
         end
         // Predict the rows of an accepted pair
         if (req_tvalid && req_tready) begin
            render_pair(req_tdata[6:0], req_tdata[21:7], req_tdata[36:22]);
            pairs_seen = pairs_seen + 1;
         end
      end
      rows_open <= rows_due.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peak meter render testbench
// Drives column pairs and register settings into the bar graph renderer with
// random gaps on the pair side and random stalls on the row side. A directed
// part covers extreme heights, fade clamping, a zero hold, the dot floor and
// extreme register values; random phases then hammer a few pairs under random
// settings so that holds expire and bars and dots fall. Checking is done by
// the checker module; this top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import sbpm_pkg::*;

   localparam int COLUMNS       = 256;
   localparam int ROWS          = 64;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_PAIRS   = 40;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 3'd7;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int         rows_open;
   int         error_count;
   int         pairs_seen;
   int         rows_checked;
   int         quiet_cycles    = 0;
   int         settings_loaded = 0;
   bit         sender_calm     = 1'b0;
   bit         receiver_calm   = 1'b0;
   logic [6:0] hot_pairs [4];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   spectrum_bar_peak_meter_render #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   meter_checker #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .rows_open    (rows_open),
      .error_count  (error_count),
      .pairs_seen   (pairs_seen),
      .rows_checked (rows_checked)
   );

   // Count cycles in which no word moves; give up past the limit
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles, %0d row words owed",
                  QUIET_LIMIT, rows_open);
         $display("[spectrum_bar_peak_meter_render] ERROR");
         $finish;
      end
   end

   // Row side: stall a random number of cycles before each word,
   // with calm stretches of no stalling
   initial begin
      int pause;
      forever begin
         if ($urandom_range(0, 31) == 0) receiver_calm = !receiver_calm;
         pause = receiver_calm ? 0 : $urandom_range(0, 7);
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write every register; unused upper bits carry noise
   task automatic load_settings(logic [3:0] bar_c, logic [3:0] dot_c, logic [3:0] fade,
                                logic [7:0] hold, logic [14:0] dstep,
                                logic [15:0] floor_lvl, logic [7:0] gain);
      logic [15:0] junk;
      junk = 16'($urandom);
      write_reg(CSR_BODY_GRAY,       {junk[15:4], bar_c});
      write_reg(CSR_PEAK_GRAY,       {junk[11:0], dot_c});
      write_reg(CSR_FADE_ROWS,       {~junk[15:4], fade});
      write_reg(CSR_DOT_HOLD_FRAMES, {junk[7:0], hold});
      write_reg(CSR_DOT_FALL_STEP,   {junk[0], dstep});
      write_reg(CSR_DOT_FLOOR_LEVEL, floor_lvl);
      write_reg(CSR_SPARE,           ~junk);
      write_reg(CSR_BAR_FALL_GAIN,   {junk[15:8], gain});
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   // Offer one pair word after a random gap and hold it until taken
   task automatic send_pair(logic [6:0] pair, logic [14:0] h_even, logic [14:0] h_odd);
      int gap;
      if ($urandom_range(0, 15) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, h_odd, h_even, pair};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering pairs, wait until every predicted row has come back
   task automatic settle_rows();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (rows_open != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Heights: zero, full scale, low range or anything
   function automatic logic [14:0] draw_height();
      case ($urandom_range(0, 7))
         0:       return 15'd0;
         1:       return 15'h7FFF;
         2, 3:    return 15'($urandom_range(0, 4095));
         default: return 15'($urandom);
      endcase
   endfunction

   // Register values: often an extreme, otherwise anything in range
   function automatic int draw_setting(int hi);
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return hi;
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   initial begin
      logic [15:0] floor_val;
      logic [7:0]  hold_val;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset values: extremes of the heights and of the pair index
      send_pair(7'd0,   15'd0,    15'd0);
      send_pair(7'd127, 15'h7FFF, 15'h7FFF);
      send_pair(7'd127, 15'd0,    15'd0);
      send_pair(7'd1,   15'd511,  15'd512);
      send_pair(7'd1,   15'd0,    15'd0);
      send_pair(7'h55,  15'h2AAA, 15'h5555);
      send_pair(7'h2A,  15'h5555, 15'h2AAA);
      send_pair(7'd3,   15'd2560, 15'd2048);
      send_pair(7'd3,   15'd1000, 15'd30000);
      send_pair(7'd64,  15'h7FFF, 15'd1);
      settle_rows();

      // Dark colors with a deep fade (negative fade clamps), zero hold,
      // fastest falls and the lowest dot floor
      load_settings(4'd0, 4'd0, 4'd15, 8'd0, 15'h7FFF, 16'h8000, 8'd255);
      send_pair(7'd2,   15'h7FFF, 15'd16384);
      send_pair(7'd2,   15'd0,    15'd0);
      send_pair(7'd2,   15'd0,    15'd0);
      send_pair(7'd127, 15'd100,  15'h7FFF);
      send_pair(7'd0,   15'h7FFF, 15'd0);
      settle_rows();

      // No fade, no falls, dot lifted to the highest floor right away
      load_settings(4'd15, 4'd15, 4'd0, 8'd0, 15'd0, 16'h7FFF, 8'd0);
      send_pair(7'd9,  15'd5000,  15'd0);
      send_pair(7'd9,  15'd0,     15'd0);
      send_pair(7'd10, 15'h7FFF,  15'h7FFF);
      send_pair(7'd0,  15'd0,     15'd0);
      settle_rows();

      // Random settings; most pairs land on a few busy columns
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         hold_val  = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 8))
                                                 : 8'(draw_setting(255));
         floor_val = ($urandom_range(0, 1) == 0) ? 16'(draw_setting(65535))
                                                 : 16'($urandom_range(0, 8192));
         load_settings(4'(draw_setting(15)), 4'(draw_setting(15)), 4'(draw_setting(15)),
                       hold_val, 15'(draw_setting(32767)), floor_val,
                       8'(draw_setting(255)));
         foreach (hot_pairs[i]) hot_pairs[i] = 7'($urandom);
         for (int n = 0; n < PHASE_PAIRS; n++)
            send_pair(($urandom_range(0, 3) != 0) ? hot_pairs[$urandom_range(0, 3)]
                                                  : 7'($urandom),
                      draw_height(), draw_height());
         settle_rows();
      end

      $display("Rendered %0d column pairs under the reset values and %0d register settings,",
               pairs_seen, settings_loaded);
      $display("compared %0d row words: %0d mismatches, %0d rows still owed.",
               rows_checked, error_count, rows_open);
      if (error_count == 0 && rows_open == 0)
         $display("[spectrum_bar_peak_meter_render] OK");
      else
         $display("[spectrum_bar_peak_meter_render] ERROR");
      $finish;
   end

endmodule
